// File: src/bbt_pkg.sv
// bbt_pkg: shared constants, datapath op codes and controller/datapath structs
// for the bollinger band tracker; no dependencies
`default_nettype none
package bbt_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int PRICE_BITS = 24;

	localparam int WLEN_W    = 7;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int MID_W     = 24;
	localparam int BAND_W    = 28;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN     = 1'd1;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int HELD_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (HELD_W > WLEN_W) ? HELD_W : WLEN_W;
	localparam int SUM_W  = PRICE_BITS + SLOT_W;
	localparam int SQ_W   = 2 * PRICE_BITS + SLOT_W;
	localparam int HALF_W = SQ_W / 2;
	localparam int X_W    = SQ_W + CMP_W;
	localparam int DVS_W  = 2 * CMP_W;
	localparam int ROOT_W = PRICE_BITS;
	localparam int RAD_W  = 2 * PRICE_BITS;
	localparam int OFF_W  = GAIN_W + ROOT_W - GAIN_FRAC;
	localparam int EXT_W  = ((OFF_W > MID_W) ? OFF_W : MID_W) + 3;
	localparam int CNT_W  = $clog2(X_W + 1);

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
	localparam logic [OP_W-1:0] OP_ACC      = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV_S    = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd4;
	localparam logic [OP_W-1:0] OP_MID      = 4'd5;
	localparam logic [OP_W-1:0] OP_NQ_HI    = 4'd6;
	localparam logic [OP_W-1:0] OP_DIV_X    = 4'd7;
	localparam logic [OP_W-1:0] OP_SQ_LOAD  = 4'd8;
	localparam logic [OP_W-1:0] OP_SQ_STEP  = 4'd9;
	localparam logic [OP_W-1:0] OP_OFF      = 4'd10;
	localparam logic [OP_W-1:0] OP_OUT      = 4'd11;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic acc_done;
		logic bands_ok;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: src/bollinger_band_tracker_core.sv
// bollinger_band_tracker_core: top level with configuration registers
// depends on bbt_pkg, bbt_ctrl and bbt_dp
//
// One closing price beat in, one band beat out. Each price goes into a 64-entry
// ring; the window sum and sum of squares are rebuilt from the ring one entry
// per cycle, then a shared one-bit-per-cycle divider runs twice (mean, then
// variance over 61 dividend bits) and a two-bit-per-step root runs 24 steps.
// While fewer than N prices are held (N = window length), the divider and the root
// are skipped. Either way the finished result waits for the output
// register to free. The next price beat is taken once the current one is
// finished, even while its result still waits in the output register.
`default_nettype none
module bollinger_band_tracker_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [bbt_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [bbt_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [23:0]                         close_price,
	input  wire logic                                new_series,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     bands_ready,
	output logic [bbt_pkg::MID_W-1:0]                middle_band,
	output logic [bbt_pkg::BAND_W-1:0]               upper_band,
	output logic signed [bbt_pkg::BAND_W-1:0]        lower_band
);

	logic [bbt_pkg::WLEN_W-1:0] window_length_q;
	logic [bbt_pkg::GAIN_W-1:0] gain_q;
	bbt_pkg::cmd_t              cmd;
	bbt_pkg::stat_t             st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= bbt_pkg::WLEN_RESET;
			gain_q          <= bbt_pkg::GAIN_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				bbt_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[bbt_pkg::WLEN_W-1:0];
				bbt_pkg::REG_BAND_GAIN:     gain_q          <= cfg_data[bbt_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	bbt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.window_length   (window_length_q),
		.band_width_gain (gain_q),
		.close_price     (close_price),
		.new_series      (new_series),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bands_ready     (bands_ready),
		.middle_band     (middle_band),
		.upper_band      (upper_band),
		.lower_band      (lower_band)
	);

endmodule
`default_nettype wire

// File: src/bbt_ctrl.sv
// bbt_ctrl: sequencing state machine of the bollinger band tracker
// depends on bbt_pkg; drives bbt_dp through cmd_t and reads stat_t
`default_nettype none
module bbt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output bbt_pkg::cmd_t      cmd,
	input  wire bbt_pkg::stat_t st
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ACC  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_DIVS = 4'd3;
	localparam logic [3:0] S_MID  = 4'd4;
	localparam logic [3:0] S_NQH  = 4'd5;
	localparam logic [3:0] S_XL   = 4'd6;
	localparam logic [3:0] S_DIVX = 4'd7;
	localparam logic [3:0] S_SQL  = 4'd8;
	localparam logic [3:0] S_SQS  = 4'd9;
	localparam logic [3:0] S_OFF  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0]              state_q, state_d;
	logic [bbt_pkg::CNT_W-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = bbt_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = bbt_pkg::OP_ACCEPT;
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.op = bbt_pkg::OP_ACC;
				if (st.acc_done) state_d = S_CHK;
			end
			S_CHK: begin
				if (st.bands_ok) begin
					cmd.op  = bbt_pkg::OP_DIV_S;
					cnt_d   = bbt_pkg::CNT_W'(bbt_pkg::X_W);
					state_d = S_DIVS;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIVS: begin
				cmd.op = bbt_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == bbt_pkg::CNT_W'(1)) state_d = S_MID;
			end
			S_MID: begin
				cmd.op  = bbt_pkg::OP_MID;
				state_d = S_NQH;
			end
			S_NQH: begin
				cmd.op  = bbt_pkg::OP_NQ_HI;
				state_d = S_XL;
			end
			S_XL: begin
				cmd.op  = bbt_pkg::OP_DIV_X;
				cnt_d   = bbt_pkg::CNT_W'(bbt_pkg::X_W);
				state_d = S_DIVX;
			end
			S_DIVX: begin
				cmd.op = bbt_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == bbt_pkg::CNT_W'(1)) state_d = S_SQL;
			end
			S_SQL: begin
				cmd.op  = bbt_pkg::OP_SQ_LOAD;
				cnt_d   = bbt_pkg::CNT_W'(bbt_pkg::ROOT_W);
				state_d = S_SQS;
			end
			S_SQS: begin
				cmd.op = bbt_pkg::OP_SQ_STEP;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == bbt_pkg::CNT_W'(1)) state_d = S_OFF;
			end
			S_OFF: begin
				cmd.op  = bbt_pkg::OP_OFF;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.op  = bbt_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_ACC)
		else $error("accepted beat did not start accumulation");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVS || state_q == S_DIVX || state_q == S_SQS) |-> cnt_q != '0)
		else $error("step counter ran out inside an iteration");

	a_fin_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && st.out_free |=> state_q == S_IDLE)
		else $error("finished result not handed to output register");

endmodule
`default_nettype wire

// File: src/bbt_dp.sv
// bbt_dp: price ring, window sums, shared bit-serial divider, root and band logic
// depends on bbt_pkg; commanded by bbt_ctrl
`default_nettype none
module bbt_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire bbt_pkg::cmd_t                         cmd,
	output bbt_pkg::stat_t                             st,
	input  wire logic [bbt_pkg::WLEN_W-1:0]            window_length,
	input  wire logic [bbt_pkg::GAIN_W-1:0]            band_width_gain,
	input  wire logic [23:0]                           close_price,
	input  wire logic                                  new_series,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       bands_ready,
	output logic [bbt_pkg::MID_W-1:0]                  middle_band,
	output logic [bbt_pkg::BAND_W-1:0]                 upper_band,
	output logic signed [bbt_pkg::BAND_W-1:0]          lower_band
);

	localparam int P = bbt_pkg::PRICE_BITS;

	logic [P-1:0] ring [bbt_pkg::WINDOW_MAX];

	logic [bbt_pkg::SLOT_W-1:0] wslot_q, wslot_nx, rd_addr_q, rd_prev;
	logic [bbt_pkg::HELD_W-1:0] held_q, held_nx, rd_left_q, span_c;
	logic                       rdv_s1, out_valid_q;
	logic [P-1:0]               rdata_s1;
	logic [bbt_pkg::SUM_W-1:0]  sum_q;
	logic [bbt_pkg::SQ_W-1:0]   sq_q;
	logic [bbt_pkg::CMP_W-1:0]  n_c;
	logic                       ready_c;

	logic [2*P-1:0]                                           sq_prod;
	logic [bbt_pkg::CMP_W+bbt_pkg::HALF_W-1:0]                nq_lo_prod;
	logic [bbt_pkg::CMP_W+bbt_pkg::SQ_W-bbt_pkg::HALF_W-1:0]  nq_hi_prod;
	logic [2*bbt_pkg::SUM_W-1:0]                              ss_prod;
	logic [bbt_pkg::DVS_W-1:0]                                nn_prod;

	logic [bbt_pkg::X_W-1:0]    nq_q, dv_quo_q;
	logic [bbt_pkg::DVS_W-1:0]  dv_rem_q, dvs_q;
	logic [bbt_pkg::DVS_W:0]    dv_t;
	logic                       dv_ge;

	logic [P-1:0]               mid_q;
	logic [bbt_pkg::RAD_W-1:0]  rad_q;
	logic [bbt_pkg::ROOT_W:0]   sq_rem_q;
	logic [bbt_pkg::ROOT_W-1:0] root_q;
	logic [bbt_pkg::ROOT_W+2:0] sq_r4, sq_t;
	logic                       sq_ge;
	logic [bbt_pkg::OFF_W-1:0]  off_q;
	logic [bbt_pkg::GAIN_W+bbt_pkg::ROOT_W-1:0] off_prod;

	logic [bbt_pkg::EXT_W-1:0]        up_ext;
	logic signed [bbt_pkg::EXT_W-1:0] lo_ext;
	logic [bbt_pkg::MID_W-1:0]        mid_sat;
	logic [bbt_pkg::BAND_W-1:0]       up_sat;
	logic signed [bbt_pkg::BAND_W-1:0] lo_sat;

	// window bookkeeping
	always_comb begin
		n_c = (window_length == '0) ? bbt_pkg::CMP_W'(1)
		                           : bbt_pkg::CMP_W'(window_length);
		if (new_series)
			held_nx = bbt_pkg::HELD_W'(1);
		else if (held_q == bbt_pkg::HELD_W'(bbt_pkg::WINDOW_MAX))
			held_nx = held_q;
		else
			held_nx = held_q + 1'b1;
		span_c = (n_c < bbt_pkg::CMP_W'(held_nx)) ? n_c[bbt_pkg::HELD_W-1:0] : held_nx;
		ready_c = bbt_pkg::CMP_W'(held_q) >= n_c;
		wslot_nx = (wslot_q == bbt_pkg::SLOT_W'(bbt_pkg::WINDOW_MAX - 1)) ? '0
		                                                                  : wslot_q + 1'b1;
		rd_prev = (rd_addr_q == '0) ? bbt_pkg::SLOT_W'(bbt_pkg::WINDOW_MAX - 1)
		                            : rd_addr_q - 1'b1;
	end

	assign sq_prod    = rdata_s1 * rdata_s1;
	assign nq_lo_prod = n_c * sq_q[bbt_pkg::HALF_W-1:0];
	assign nq_hi_prod = n_c * sq_q[bbt_pkg::SQ_W-1:bbt_pkg::HALF_W];
	assign ss_prod    = sum_q * sum_q;
	assign nn_prod    = n_c * n_c;

	// shared restoring divider step
	always_comb begin
		dv_t  = {dv_rem_q, dv_quo_q[bbt_pkg::X_W-1]};
		dv_ge = dv_t >= {1'b0, dvs_q};
	end

	// root step, two radicand bits per step
	always_comb begin
		sq_r4 = {sq_rem_q, rad_q[bbt_pkg::RAD_W-1 -: 2]};
		sq_t  = (bbt_pkg::ROOT_W+3)'({root_q, 2'b01});
		sq_ge = sq_r4 >= sq_t;
	end

	assign off_prod = band_width_gain * root_q;

	// band saturation
	always_comb begin
		up_ext = bbt_pkg::EXT_W'(mid_q) + bbt_pkg::EXT_W'(off_q);
		lo_ext = $signed(bbt_pkg::EXT_W'(mid_q)) - $signed(bbt_pkg::EXT_W'(off_q));
		if (bbt_pkg::EXT_W'(mid_q) > bbt_pkg::EXT_W'({bbt_pkg::MID_W{1'b1}}))
			mid_sat = {bbt_pkg::MID_W{1'b1}};
		else
			mid_sat = bbt_pkg::MID_W'(mid_q);
		if (up_ext > bbt_pkg::EXT_W'({bbt_pkg::BAND_W{1'b1}}))
			up_sat = {bbt_pkg::BAND_W{1'b1}};
		else
			up_sat = up_ext[bbt_pkg::BAND_W-1:0];
		if (lo_ext < $signed({{(bbt_pkg::EXT_W-bbt_pkg::BAND_W+1){1'b1}},
		                      {(bbt_pkg::BAND_W-1){1'b0}}}))
			lo_sat = {1'b1, {(bbt_pkg::BAND_W-1){1'b0}}};
		else if (lo_ext > $signed({{(bbt_pkg::EXT_W-bbt_pkg::BAND_W+1){1'b0}},
		                           {(bbt_pkg::BAND_W-1){1'b1}}}))
			lo_sat = {1'b0, {(bbt_pkg::BAND_W-1){1'b1}}};
		else
			lo_sat = lo_ext[bbt_pkg::BAND_W-1:0];
	end

	assign st.acc_done = (rd_left_q == '0) && !rdv_s1;
	assign st.bands_ok = ready_c;
	assign st.out_free = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.op == bbt_pkg::OP_ACCEPT) ring[wslot_q] <= close_price[P-1:0];
		rdata_s1 <= ring[rd_prev];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q     <= '0;
			held_q      <= '0;
			rd_addr_q   <= '0;
			rd_left_q   <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= 1'b0;
			if (cmd.op == bbt_pkg::OP_ACCEPT) begin
				wslot_q   <= wslot_nx;
				held_q    <= held_nx;
				rd_addr_q <= wslot_nx;
				rd_left_q <= span_c;
			end
			if (cmd.op == bbt_pkg::OP_ACC && rd_left_q != '0) begin
				rd_addr_q <= rd_prev;
				rd_left_q <= rd_left_q - 1'b1;
				rdv_s1    <= 1'b1;
			end
			if (cmd.op == bbt_pkg::OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bbt_pkg::OP_ACCEPT: begin
				sum_q <= '0;
				sq_q  <= '0;
			end
			bbt_pkg::OP_ACC: begin
				if (rdv_s1) begin
					sum_q <= sum_q + bbt_pkg::SUM_W'(rdata_s1);
					sq_q  <= sq_q + bbt_pkg::SQ_W'(sq_prod);
				end
			end
			bbt_pkg::OP_DIV_S: begin
				dv_rem_q <= '0;
				dv_quo_q <= bbt_pkg::X_W'(sum_q);
				dvs_q    <= bbt_pkg::DVS_W'(n_c);
			end
			bbt_pkg::OP_DIV_STEP: begin
				dv_rem_q <= dv_ge ? bbt_pkg::DVS_W'(dv_t - {1'b0, dvs_q})
				                  : dv_t[bbt_pkg::DVS_W-1:0];
				dv_quo_q <= {dv_quo_q[bbt_pkg::X_W-2:0], dv_ge};
			end
			bbt_pkg::OP_MID: begin
				mid_q <= dv_quo_q[P-1:0];
				nq_q  <= bbt_pkg::X_W'(nq_lo_prod);
			end
			bbt_pkg::OP_NQ_HI: begin
				nq_q <= nq_q + (bbt_pkg::X_W'(nq_hi_prod) << bbt_pkg::HALF_W);
			end
			bbt_pkg::OP_DIV_X: begin
				dv_rem_q <= '0;
				dv_quo_q <= nq_q - bbt_pkg::X_W'(ss_prod);
				dvs_q    <= nn_prod;
			end
			bbt_pkg::OP_SQ_LOAD: begin
				rad_q    <= dv_quo_q[bbt_pkg::RAD_W-1:0];
				sq_rem_q <= '0;
				root_q   <= '0;
			end
			bbt_pkg::OP_SQ_STEP: begin
				sq_rem_q <= sq_ge ? (bbt_pkg::ROOT_W+1)'(sq_r4 - sq_t)
				                  : (bbt_pkg::ROOT_W+1)'(sq_r4);
				root_q   <= {root_q[bbt_pkg::ROOT_W-2:0], sq_ge};
				rad_q    <= rad_q << 2;
			end
			bbt_pkg::OP_OFF: begin
				off_q <= off_prod[bbt_pkg::GAIN_FRAC +: bbt_pkg::OFF_W];
			end
			bbt_pkg::OP_OUT: begin
				bands_ready <= ready_c;
				middle_band <= ready_c ? mid_sat : '0;
				upper_band  <= ready_c ? up_sat : '0;
				lower_band  <= ready_c ? lo_sat : '0;
			end
			default: begin
			end
		endcase
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= bbt_pkg::HELD_W'(bbt_pkg::WINDOW_MAX))
		else $error("held count above ring depth");

	a_reads_within_history: assert property (@(posedge clk) disable iff (!arst_n)
		rd_left_q <= held_q)
		else $error("ring read reaches past written history");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !bands_ready |-> middle_band == '0 && upper_band == '0
		                                && lower_band == '0)
		else $error("bands nonzero while not ready");

endmodule
`default_nettype wire

// File: tb/sv/bollinger_band_tracker_core_tb.sv
// bollinger_band_tracker_core_tb: self-checking bench for the band tracker core
// keeps its own price ring and band arithmetic, checks every band beat in order
// depends on bbt_pkg and bollinger_band_tracker_core
`default_nettype none
module bollinger_band_tracker_core_tb;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic                              ready;
		logic [bbt_pkg::MID_W-1:0]         mid;
		logic [bbt_pkg::BAND_W-1:0]        upper;
		logic [bbt_pkg::BAND_W-1:0]        lower;
	} bands_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [bbt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [bbt_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [23:0] close_price = '0;
	logic new_series = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic bands_ready;
	logic [bbt_pkg::MID_W-1:0] middle_band;
	logic [bbt_pkg::BAND_W-1:0] upper_band;
	logic signed [bbt_pkg::BAND_W-1:0] lower_band;

	bollinger_band_tracker_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.close_price(close_price), .new_series(new_series),
		.out_valid(out_valid), .out_ready(out_ready),
		.bands_ready(bands_ready), .middle_band(middle_band),
		.upper_band(upper_band), .lower_band(lower_band)
	);

	// predictor state
	logic [23:0] hist [bbt_pkg::WINDOW_MAX];
	int unsigned next_slot;
	int unsigned held;
	logic [6:0] win_len;
	logic [15:0] gain;

	bands_t pending_bands[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int ready_beats = 0;
	int cycles = 0;
	bit no_idle = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bands_t band_predict(logic [23:0] price, logic restart);
		longint unsigned n, span, s, q, mid, r, d, a, b, e, var_q, dev, off, up;
		longint signed lo;
		int unsigned slot;
		bands_t res;
		n = win_len;
		if (n == 0) n = 1;
		if (restart) held = 0;
		hist[next_slot] = price;
		next_slot = (next_slot + 1 >= bbt_pkg::WINDOW_MAX) ? 0 : next_slot + 1;
		if (held < bbt_pkg::WINDOW_MAX) held++;
		span = (n < held) ? n : held;
		s = 0;
		q = 0;
		slot = next_slot;
		for (int k = 0; k < span; k++) begin
			slot = (slot == 0) ? bbt_pkg::WINDOW_MAX - 1 : slot - 1;
			s += hist[slot];
			q += longint'(hist[slot]) * longint'(hist[slot]);
		end
		res = '0;
		if (held < n) return res;
		mid = s / n;
		r = s - mid * n;
		d = q + n * mid * mid - 2 * mid * s;
		a = (r * r) / n;
		b = (r * r) - a * n;
		e = (d >= a) ? d - a : 0;
		if (b == 0) var_q = e / n;
		else var_q = (e >= 1) ? (e - 1) / n : 0;
		dev = int_sqrt(var_q);
		off = (longint'(gain) * dev) >> bbt_pkg::GAIN_FRAC;
		up = mid + off;
		if (up > 64'h0FFF_FFFF) up = 64'h0FFF_FFFF;
		lo = longint'(mid) - longint'(off);
		if (lo < -64'sh0800_0000) lo = -64'sh0800_0000;
		if (lo > 64'sh07FF_FFFF) lo = 64'sh07FF_FFFF;
		if (mid > 64'hFF_FFFF) mid = 64'hFF_FFFF;
		res.ready = 1'b1;
		res.mid = mid[bbt_pkg::MID_W-1:0];
		res.upper = up[bbt_pkg::BAND_W-1:0];
		res.lower = lo[bbt_pkg::BAND_W-1:0];
		return res;
	endfunction

	// band beat checker
	always @(posedge clk) begin
		bands_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_bands.size() == 0) begin
				$display("%0t: unexpected band beat ready=%0d mid=%0d", $time,
					bands_ready, middle_band);
				errors++;
			end else begin
				exp_b = pending_bands.pop_front();
				if (exp_b.ready) ready_beats++;
				if (bands_ready !== exp_b.ready) begin
					$display("%0t: bands_ready exp %0d got %0d", $time, exp_b.ready,
						bands_ready);
					errors++;
				end
				if (middle_band !== exp_b.mid) begin
					$display("%0t: middle_band exp %0d got %0d", $time, exp_b.mid,
						middle_band);
					errors++;
				end
				if (upper_band !== exp_b.upper) begin
					$display("%0t: upper_band exp %0d got %0d", $time, exp_b.upper,
						upper_band);
					errors++;
				end
				if (lower_band !== exp_b.lower) begin
					$display("%0t: lower_band exp %0d got %0d", $time,
						$signed(exp_b.lower), lower_band);
					errors++;
				end
			end
		end
	end

	// output side stalls
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			k = no_idle ? 0 : $urandom_range(0, 3);
			if (k > 0) begin
				out_ready = 1'b0;
				repeat (k) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_price(logic [23:0] price, logic restart);
		int k;
		k = no_idle ? 0 : $urandom_range(0, 3);
		if (k > 0) begin
			in_valid = 1'b0;
			repeat (k) @(negedge clk);
		end
		close_price = price;
		new_series = restart;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_bands.push_back(band_predict(price, restart));
		beats_in++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bands.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [bbt_pkg::CFG_IDX_W-1:0] idx,
		logic [bbt_pkg::CFG_W-1:0] data);
		cfg_idx = idx;
		cfg_data = data;
		cfg_wen = 1'b1;
		@(negedge clk);
		cfg_wen = 1'b0;
		if (idx == bbt_pkg::REG_WINDOW_LENGTH) win_len = data[6:0];
		else gain = data;
	endtask

	task automatic set_bands(logic [15:0] n, logic [15:0] g);
		wait_drained();
		write_reg(bbt_pkg::REG_WINDOW_LENGTH, n);
		write_reg(bbt_pkg::REG_BAND_GAIN, g);
	endtask

	function automatic logic [23:0] rand_price(int mode);
		case (mode)
			0: return 24'($urandom());
			1: return 24'($urandom_range(0, 255));
			2: return 24'hFFFFFF - 24'($urandom_range(0, 15));
			3: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
			default: return 24'd1000000 + 24'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic test_directed();
		// reset values still in place: window 20, gain 2.0
		send_price(24'h0, 1'b0);
		send_price(24'hFFFFFF, 1'b0);
		set_bands(16'd1, 16'd4096);
		send_price(24'hFFFFFF, 1'b0);
		send_price(24'h0, 1'b1);
		set_bands(16'd0, 16'hFFFF);
		send_price(24'h123456, 1'b0);
		set_bands(16'd2, 16'hFFFF);
		send_price(24'h0, 1'b1);
		send_price(24'hFFFFFF, 1'b0);
		send_price(24'h0, 1'b0);
		send_price(24'hFFFFFF, 1'b0);
		set_bands(16'd64, 16'hFFFF);
		for (int i = 0; i < 66; i++)
			send_price((i % 2) ? 24'hFFFFFF : 24'h0, i == 0);
		set_bands(16'd3, 16'd0);
		send_price(24'd7, 1'b1);
		send_price(24'd7, 1'b0);
		send_price(24'd8, 1'b0);
		set_bands(16'd100, 16'd8192);
		send_price(24'hABCDEF, 1'b0);
		set_bands(16'hFF85, 16'd8192);
		send_price(24'h555555, 1'b0);
	endtask

	task automatic test_random(int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				mode = $urandom_range(0, 4);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			send_price(rand_price(mode), $urandom_range(0, 29) == 0);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_window_sweep();
		logic [15:0] lens [8] = '{16'd1, 16'd2, 16'd5, 16'd20, 16'd64, 16'd0, 16'd90, 16'd7};
		logic [15:0] gns [8] = '{16'd4096, 16'hFFFF, 16'd0, 16'd8192, 16'hFFFF,
			16'd12345, 16'd100, 16'hFFFF};
		for (int p = 0; p < 8; p++) begin
			set_bands(lens[p], ($urandom_range(0, 2) == 0) ? 16'($urandom()) : gns[p]);
			test_random(40);
		end
	endtask

	task automatic test_drain_pause();
		set_bands(16'd4, 16'd20000);
		test_random(10);
		wait_drained();
		test_random(20);
	endtask

	initial begin
		for (int i = 0; i < bbt_pkg::WINDOW_MAX; i++) hist[i] = '0;
		next_slot = 0;
		held = 0;
		win_len = bbt_pkg::WLEN_RESET;
		gain = bbt_pkg::GAIN_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_window_sweep();
		test_drain_pause();
		set_bands(16'd20, 16'd8192);
		test_random(60);
		wait_drained();
		repeat (200) @(negedge clk);
		$display("ran %0d price beats, %0d band beats checked, %0d with full window",
			beats_in, beats_out, ready_beats);
		$display("windows from zero to past the ring depth, gains 0 to 65535, series restarts");
		if (errors == 0 && pending_bands.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: bollinger_band_tracker_core.f
src/bbt_pkg.sv
src/bbt_ctrl.sv
src/bbt_dp.sv
src/bollinger_band_tracker_core.sv
tb/sv/bollinger_band_tracker_core_tb.sv
